@@ src/gtp_pkg.sv @@
// ----------------------------------------------------------------------------
// gtp_pkg: shared constants and types of the grid tile placer
// Geometry constants, codes, width constants and controller/datapath buses.
// ----------------------------------------------------------------------------
package gtp_pkg;

  // Tile geometry and map size
  localparam int TILE_WIDTH  = 200;
  localparam int TILE_HEIGHT = 150;
  localparam int CELLS       = 256;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int OWN_W       = 6;

  // Arithmetic widths
  localparam int DIV_W   = 22;
  localparam int DVSR_W  = 12;
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 12;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Input commands (tuser)
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_PLACE  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result status (tuser)
  localparam logic [2:0] ST_PLACED  = 3'd0;
  localparam logic [2:0] ST_NO_ROOM = 3'd1;
  localparam logic [2:0] ST_CLEARED = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS  = 2'd0;
  localparam logic [1:0] REG_MARGIN_X = 2'd1;
  localparam logic [1:0] REG_MARGIN_Y = 2'd2;

  // Datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_ASPECT = 4'd2;
  localparam logic [3:0] OP_SCAN   = 4'd3;
  localparam logic [3:0] OP_MARK0  = 4'd4;
  localparam logic [3:0] OP_MARK1  = 4'd5;
  localparam logic [3:0] OP_OX     = 4'd6;
  localparam logic [3:0] OP_OY     = 4'd7;
  localparam logic [3:0] OP_PA     = 4'd8;
  localparam logic [3:0] OP_PB     = 4'd9;
  localparam logic [3:0] OP_CMP    = 4'd10;
  localparam logic [3:0] OP_FIN    = 4'd11;
  localparam logic [3:0] OP_LX     = 4'd12;
  localparam logic [3:0] OP_LY     = 4'd13;
  localparam logic [3:0] OP_LMUL   = 4'd14;
  localparam logic [3:0] OP_LRD    = 4'd15;

  // Full rows of the map for each column count (index 0 acts as one column)
  localparam logic [CELL_AW:0] ROWS_TBL [32] = '{
    (CELL_AW+1)'(CELLS),      (CELL_AW+1)'(CELLS / 1),  (CELL_AW+1)'(CELLS / 2),
    (CELL_AW+1)'(CELLS / 3),  (CELL_AW+1)'(CELLS / 4),  (CELL_AW+1)'(CELLS / 5),
    (CELL_AW+1)'(CELLS / 6),  (CELL_AW+1)'(CELLS / 7),  (CELL_AW+1)'(CELLS / 8),
    (CELL_AW+1)'(CELLS / 9),  (CELL_AW+1)'(CELLS / 10), (CELL_AW+1)'(CELLS / 11),
    (CELL_AW+1)'(CELLS / 12), (CELL_AW+1)'(CELLS / 13), (CELL_AW+1)'(CELLS / 14),
    (CELL_AW+1)'(CELLS / 15), (CELL_AW+1)'(CELLS / 16), (CELL_AW+1)'(CELLS / 17),
    (CELL_AW+1)'(CELLS / 18), (CELL_AW+1)'(CELLS / 19), (CELL_AW+1)'(CELLS / 20),
    (CELL_AW+1)'(CELLS / 21), (CELL_AW+1)'(CELLS / 22), (CELL_AW+1)'(CELLS / 23),
    (CELL_AW+1)'(CELLS / 24), (CELL_AW+1)'(CELLS / 25), (CELL_AW+1)'(CELLS / 26),
    (CELL_AW+1)'(CELLS / 27), (CELL_AW+1)'(CELLS / 28), (CELL_AW+1)'(CELLS / 29),
    (CELL_AW+1)'(CELLS / 30), (CELL_AW+1)'(CELLS / 31)
  };

  // Controller to datapath
  typedef struct packed {
    logic [3:0] op;
    logic       ld_in;
    logic       ld_out;
    logic [2:0] res_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fit;
    logic scan_end;
    logic two_cell;
    logic div_done;
    logic div_busy;
    logic lk_hit;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/gtp_div.sv @@
// ----------------------------------------------------------------------------
// gtp_div: restoring divider
// Unsigned quotient, one bit per cycle, done pulses one cycle at the end.
// ----------------------------------------------------------------------------
module gtp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [gtp_pkg::DIV_W-1:0]   dividend_i,
  input  logic [gtp_pkg::DVSR_W-1:0]  divisor_i,
  output logic [gtp_pkg::DIV_W-1:0]   quotient_o,
  output logic                        done_o,
  output logic                        busy_o
);

  localparam int CNT_W = $clog2(gtp_pkg::DIV_W + 1);

  logic [gtp_pkg::DVSR_W-1:0] rem_r, dvsr_r;
  logic [gtp_pkg::DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r, done_r;
  logic [gtp_pkg::DVSR_W:0]   sh;
  logic [gtp_pkg::DVSR_W:0]   diff;
  logic                       ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    sh   = {rem_r, quo_r[gtp_pkg::DIV_W-1]};
    diff = sh - {1'b0, dvsr_r};
    ge   = sh >= {1'b0, dvsr_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(gtp_pkg::DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Shift one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= '0;
      quo_r  <= dividend_i;
      dvsr_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= ge ? diff[gtp_pkg::DVSR_W-1:0] : sh[gtp_pkg::DVSR_W-1:0];
      quo_r <= {quo_r[gtp_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient_o = quo_r;
  assign done_o     = done_r;
  assign busy_o     = busy_r;

endmodule

@@ src/gtp_dp.sv @@
// ----------------------------------------------------------------------------
// gtp_dp: grid tile placer datapath
// Config registers, occupancy map, scan counters, geometry and result word.
// ----------------------------------------------------------------------------
module gtp_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  gtp_pkg::dp_cmd_t  cmd,
  output gtp_pkg::dp_sts_t  sts,
  input  logic [63:0]       in_tdata,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [119:0]      out_tdata,
  output logic [2:0]        out_tuser
);

  localparam int AW = gtp_pkg::CELL_AW;
  localparam int MUL_A_W_L = gtp_pkg::MUL_A_W;

  // Configuration
  logic [4:0] cols_r;
  logic [7:0] mx_r, my_r;
  logic [4:0] cols_eff;
  logic [AW:0] rows;

  // Input item
  logic [5:0]  item_r;
  logic [11:0] w_r, h_r;
  logic [12:0] clx_r;
  logic [17:0] cly_r;

  // Map
  logic [gtp_pkg::OWN_W-1:0] mem [gtp_pkg::CELLS];
  logic [gtp_pkg::CELLS-1:0] occ_r;

  // Scan
  logic [AW-1:0] i_r;
  logic [4:0]    x_r;
  logic [7:0]    y_r;
  logic          fx2_r, fy2_r;
  logic [AW:0]   sec;
  logic          xfit, yfit, free_c, fit_c;

  // Aspect test
  logic signed [25:0] w_s, h_s, lhs, bnd;
  logic               wide_a, tall_a;

  // Geometry
  logic [MUL_A_W_L-1:0] mul_a;
  logic [11:0]          mul_b;
  logic [gtp_pkg::PROD_W-1:0] prod_r;
  logic [9:0]  ow_r, oh_r, iw_r, ih_r;
  logic [17:0] ox_r, oy_r, ix_r, iy_r;
  logic [21:0] a_r;
  logic        wide_r, wide_c;
  logic [9:0]  q10;

  // Divider
  logic        div_start;
  logic [21:0] div_dnd;
  logic [11:0] div_dvs;
  logic [21:0] quo;
  logic        div_done, div_busy;
  logic [11:0] pitch_x, pitch_y;
  logic [12:0] lx;
  logic [17:0] ly;

  // Lookup
  logic [12:0] qx_r;
  logic [gtp_pkg::PROD_W-1:0] cell_sum;
  logic [5:0]  rd_own_r;
  logic        rd_occ_r, inr_r;

  // Write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Output
  logic         out_valid_r;
  logic [117:0] out_data_r;
  logic [2:0]   out_st_r;
  logic         out_free;
  logic [5:0]   res_own;
  logic         placed;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 5'd4;
      mx_r   <= 8'd0;
      my_r   <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtp_pkg::REG_COLUMNS:  cols_r <= cfg_data[4:0];
        gtp_pkg::REG_MARGIN_X: mx_r   <= cfg_data;
        gtp_pkg::REG_MARGIN_Y: my_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cols_eff = (cols_r == 5'd0) ? 5'd1 : cols_r;
  assign rows     = gtp_pkg::ROWS_TBL[cols_eff];
  assign pitch_x  = 12'(gtp_pkg::TILE_WIDTH) + {4'd0, mx_r};
  assign pitch_y  = 12'(gtp_pkg::TILE_HEIGHT) + {4'd0, my_r};

  // Capture the input word, zero sizes act as one
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      item_r <= in_tdata[5:0];
      w_r    <= (in_tdata[17:6] == 12'd0) ? 12'd1 : in_tdata[17:6];
      h_r    <= (in_tdata[29:18] == 12'd0) ? 12'd1 : in_tdata[29:18];
      clx_r  <= in_tdata[42:30];
      cly_r  <= in_tdata[60:43];
    end
  end

  // Aspect test by cross-multiplication
  always_comb begin
    w_s    = $signed({14'd0, w_r});
    h_s    = $signed({14'd0, h_r});
    lhs    = 26'sd5 * ($signed(26'(gtp_pkg::TILE_HEIGHT)) * w_s
                     - $signed(26'(gtp_pkg::TILE_WIDTH)) * h_s);
    bnd    = $signed(26'(2 * gtp_pkg::TILE_WIDTH)) * w_s;
    wide_a = (lhs > bnd) && (cols_eff > 5'd1);
    tall_a = !wide_a && (lhs < -bnd);
  end

  // Candidate footprint at the scan position
  always_comb begin
    if (fx2_r) sec = {1'b0, i_r} + 1'b1;
    else if (fy2_r) sec = {1'b0, i_r} + {{(AW-4){1'b0}}, cols_eff};
    else sec = {1'b0, i_r};
    xfit   = ({1'b0, x_r} + {5'd0, fx2_r} + 6'd1) <= {1'b0, cols_eff};
    yfit   = ({1'b0, y_r} + {8'd0, fy2_r} + 9'd1) <= rows;
    free_c = !occ_r[i_r] && !occ_r[sec[AW-1:0]];
    fit_c  = xfit && yfit && free_c;
  end

  // Scan counters
  always_ff @(posedge clk) begin
    if (cmd.op == gtp_pkg::OP_ASPECT) begin
      fx2_r <= wide_a;
      fy2_r <= tall_a;
      i_r   <= '0;
      x_r   <= '0;
      y_r   <= '0;
    end else if (cmd.op == gtp_pkg::OP_SCAN && !fit_c) begin
      i_r <= i_r + 1'b1;
      if (x_r + 5'd1 == cols_eff) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // Occupancy flags: clear at once, set the footprint
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == gtp_pkg::OP_CLEAR) begin
      occ_r <= '0;
    end else if (cmd.op == gtp_pkg::OP_MARK0) begin
      occ_r[i_r]          <= 1'b1;
      occ_r[sec[AW-1:0]]  <= 1'b1;
    end
  end

  // Owner memory write and registered read
  assign wr_en   = (cmd.op == gtp_pkg::OP_MARK0) || (cmd.op == gtp_pkg::OP_MARK1);
  assign wr_addr = (cmd.op == gtp_pkg::OP_MARK1) ? sec[AW-1:0] : i_r;
  assign cell_sum = prod_r + gtp_pkg::PROD_W'(qx_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_r;
    end
    if (cmd.op == gtp_pkg::OP_LRD) begin
      rd_own_r <= mem[cell_sum[AW-1:0]];
      rd_occ_r <= occ_r[cell_sum[AW-1:0]];
      inr_r    <= cell_sum < gtp_pkg::PROD_W'(gtp_pkg::CELLS);
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (cmd.op)
      gtp_pkg::OP_OX: begin
        mul_a = MUL_A_W_L'(x_r);
        mul_b = pitch_x;
      end
      gtp_pkg::OP_OY: begin
        mul_a = MUL_A_W_L'(y_r);
        mul_b = pitch_y;
      end
      gtp_pkg::OP_PA: begin
        mul_a = MUL_A_W_L'(oh_r);
        mul_b = w_r;
      end
      gtp_pkg::OP_PB: begin
        mul_a = MUL_A_W_L'(h_r);
        mul_b = {2'd0, ow_r};
      end
      gtp_pkg::OP_LMUL: begin
        mul_a = quo[MUL_A_W_L-1:0];
        mul_b = {7'd0, cols_eff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Divider operands
  assign wide_c = a_r > prod_r[21:0];
  assign lx     = clx_r - {6'd0, mx_r[7:1]};
  assign ly     = cly_r - {11'd0, my_r[7:1]};

  always_comb begin
    div_start = 1'b0;
    div_dnd   = '0;
    div_dvs   = 12'd1;
    unique case (cmd.op)
      gtp_pkg::OP_CMP: begin
        div_start = 1'b1;
        div_dnd   = wide_c ? prod_r[21:0] : a_r;
        div_dvs   = wide_c ? w_r : h_r;
      end
      gtp_pkg::OP_LX: begin
        div_start = 1'b1;
        div_dnd   = (clx_r < {6'd0, mx_r[7:1]}) ? 22'd0 : 22'(lx);
        div_dvs   = pitch_x;
      end
      gtp_pkg::OP_LY: begin
        div_start = 1'b1;
        div_dnd   = (cly_r < {11'd0, my_r[7:1]}) ? 22'd0 : 22'(ly);
        div_dvs   = pitch_y;
      end
      default: ;
    endcase
  end

  gtp_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dnd),
    .divisor_i  (div_dvs),
    .quotient_o (quo),
    .done_o     (div_done),
    .busy_o     (div_busy)
  );

  // Rectangle registers
  assign q10 = quo[9:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gtp_pkg::OP_OX: begin
        ow_r <= fx2_r ? 10'(2 * gtp_pkg::TILE_WIDTH) + {2'd0, mx_r}
                      : 10'(gtp_pkg::TILE_WIDTH);
        oh_r <= fy2_r ? 10'(2 * gtp_pkg::TILE_HEIGHT) + {2'd0, my_r}
                      : 10'(gtp_pkg::TILE_HEIGHT);
      end
      gtp_pkg::OP_OY: ox_r <= prod_r[17:0] + {11'd0, mx_r[7:1]};
      gtp_pkg::OP_PA: oy_r <= prod_r[17:0] + {11'd0, my_r[7:1]};
      gtp_pkg::OP_PB: a_r  <= prod_r[21:0];
      gtp_pkg::OP_CMP: wide_r <= wide_c;
      gtp_pkg::OP_FIN: begin
        if (wide_r) begin
          iw_r <= ow_r;
          ih_r <= q10;
          ix_r <= ox_r;
          iy_r <= oy_r + {9'd0, 9'((oh_r - q10) >> 1)};
        end else begin
          iw_r <= q10;
          ih_r <= oh_r;
          ix_r <= ox_r + {9'd0, 9'((ow_r - q10) >> 1)};
          iy_r <= oy_r;
        end
      end
      gtp_pkg::OP_LY: qx_r <= quo[12:0];
      default: ;
    endcase
  end

  // Result word
  assign out_free = !out_valid_r || out_tready;
  assign placed   = cmd.res_status == gtp_pkg::ST_PLACED;

  always_comb begin
    if (placed || cmd.res_status == gtp_pkg::ST_NO_ROOM) res_own = item_r;
    else if (cmd.res_status == gtp_pkg::ST_HIT) res_own = rd_own_r;
    else res_own = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_st_r   <= cmd.res_status;
      out_data_r <= placed ? {ih_r, iw_r, iy_r, ix_r, oh_r, ow_r, oy_r, ox_r, res_own}
                           : {112'd0, res_own};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'd0, out_data_r};
  assign out_tuser  = out_st_r;

  // Status
  always_comb begin
    sts.fit      = fit_c;
    sts.scan_end = i_r == {AW{1'b1}};
    sts.two_cell = fx2_r || fy2_r;
    sts.div_done = div_done;
    sts.div_busy = div_busy;
    sts.lk_hit   = inr_r && rd_occ_r;
    sts.out_free = out_free;
  end

endmodule

@@ src/gtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// gtp_ctrl: grid tile placer controller
// Sequences clear, first-fit place and lookup through the datapath.
// ----------------------------------------------------------------------------
module gtp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  gtp_pkg::dp_sts_t  sts,
  output gtp_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_ASP  = 5'd2;
  localparam logic [4:0] S_SCAN = 5'd3;
  localparam logic [4:0] S_MK0  = 5'd4;
  localparam logic [4:0] S_MK1  = 5'd5;
  localparam logic [4:0] S_OX   = 5'd6;
  localparam logic [4:0] S_OY   = 5'd7;
  localparam logic [4:0] S_PA   = 5'd8;
  localparam logic [4:0] S_PB   = 5'd9;
  localparam logic [4:0] S_CMP  = 5'd10;
  localparam logic [4:0] S_DW   = 5'd11;
  localparam logic [4:0] S_FIN  = 5'd12;
  localparam logic [4:0] S_LX   = 5'd13;
  localparam logic [4:0] S_LXW  = 5'd14;
  localparam logic [4:0] S_LY   = 5'd15;
  localparam logic [4:0] S_LYW  = 5'd16;
  localparam logic [4:0] S_LM   = 5'd17;
  localparam logic [4:0] S_LRD  = 5'd18;
  localparam logic [4:0] S_LCHK = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;
  logic       accept;

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;

  // Next state and datapath command
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd.op         = gtp_pkg::OP_NOP;
    cmd.ld_in      = accept;
    cmd.ld_out     = 1'b0;
    cmd.res_status = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            gtp_pkg::CMD_CLEAR:  state_nxt = S_CLR;
            gtp_pkg::CMD_PLACE:  state_nxt = S_ASP;
            gtp_pkg::CMD_LOOKUP: state_nxt = S_LX;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.op    = gtp_pkg::OP_CLEAR;
        res_nxt   = gtp_pkg::ST_CLEARED;
        state_nxt = S_OUT;
      end
      S_ASP: begin
        cmd.op    = gtp_pkg::OP_ASPECT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = gtp_pkg::OP_SCAN;
        priority if (sts.fit) begin
          state_nxt = S_MK0;
        end else if (sts.scan_end) begin
          res_nxt   = gtp_pkg::ST_NO_ROOM;
          state_nxt = S_OUT;
        end
      end
      S_MK0: begin
        cmd.op    = gtp_pkg::OP_MARK0;
        state_nxt = sts.two_cell ? S_MK1 : S_OX;
      end
      S_MK1: begin
        cmd.op    = gtp_pkg::OP_MARK1;
        state_nxt = S_OX;
      end
      S_OX: begin
        cmd.op    = gtp_pkg::OP_OX;
        state_nxt = S_OY;
      end
      S_OY: begin
        cmd.op    = gtp_pkg::OP_OY;
        state_nxt = S_PA;
      end
      S_PA: begin
        cmd.op    = gtp_pkg::OP_PA;
        state_nxt = S_PB;
      end
      S_PB: begin
        cmd.op    = gtp_pkg::OP_PB;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = gtp_pkg::OP_CMP;
        state_nxt = S_DW;
      end
      S_DW: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = gtp_pkg::OP_FIN;
        res_nxt   = gtp_pkg::ST_PLACED;
        state_nxt = S_OUT;
      end
      S_LX: begin
        cmd.op    = gtp_pkg::OP_LX;
        state_nxt = S_LXW;
      end
      S_LXW: begin
        if (sts.div_done) state_nxt = S_LY;
      end
      S_LY: begin
        cmd.op    = gtp_pkg::OP_LY;
        state_nxt = S_LYW;
      end
      S_LYW: begin
        if (sts.div_done) state_nxt = S_LM;
      end
      S_LM: begin
        cmd.op    = gtp_pkg::OP_LMUL;
        state_nxt = S_LRD;
      end
      S_LRD: begin
        cmd.op    = gtp_pkg::OP_LRD;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        res_nxt   = sts.lk_hit ? gtp_pkg::ST_HIT : gtp_pkg::ST_MISS;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= gtp_pkg::ST_CLEARED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

@@ src/grid_tile_placer.sv @@
// ----------------------------------------------------------------------------
// grid_tile_placer: first-fit tile placement on a grid occupancy map
// Clear, place and lookup commands against a 256-cell occupancy map.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command word; tuser holds the command
//   (clear, place, lookup) and tdata the item index, image size and click
//   point. Each clear, place or lookup yields exactly one result word on the
//   output stream, with the status in tuser and owner plus rectangles in
//   tdata. An unused command code is taken and dropped without a result.
//   The configuration channel writes columns, margin_x and margin_y; write
//   it only while the block is idle.
//   One command is worked at a time. Lookup makes two bit-serial divider
//   passes. Place runs a first-fit scan that visits 1 to 256 cells, one
//   candidate per cycle, marks the footprint (a second step for a two-cell
//   footprint), and one bit-serial divider pass fits the image; no_room
//   returns after a full scan.
//   A finished result sits in the output register; the next command is
//   accepted while it waits. A stalled receiver holds only the following
//   result. Reset empties the map at once and restores columns 4,
//   margin_x 0, margin_y 10.
// ----------------------------------------------------------------------------
module grid_tile_placer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // item_index, image_width, image_height, click_x, click_y
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // owner_index, outer_x, outer_y, outer_w, outer_h,
                                   // inner_x, inner_y, inner_w, inner_h
  output logic [2:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  gtp_pkg::dp_cmd_t ctl;
  gtp_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (ctl)
  );

  gtp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |-> sts.out_free)
    else $error("result loaded over a pending word");

  // The divider is started only when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == gtp_pkg::OP_CMP || ctl.op == gtp_pkg::OP_LX ||
     ctl.op == gtp_pkg::OP_LY) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // Divider completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |=> !sts.div_done)
    else $error("divider done held");
`endif

endmodule

@@ bench/gtp_checker.sv @@
// ----------------------------------------------------------------------------
// gtp_checker: result predictor and scoreboard for the grid tile placer
// Watches the command, configuration and result streams, keeps its own copy
// of the occupancy map and registers, and compares every result word.
// ----------------------------------------------------------------------------
module gtp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  owner;
    logic [17:0] ox, oy;
    logic [9:0]  ow, oh;
    logic [17:0] ix, iy;
    logic [9:0]  iw, ih;
  } tile_res_t;

  tile_res_t  expected_tiles[$];
  logic [6:0] map_copy [gtp_pkg::CELLS];
  logic [4:0] reg_cols;
  logic [7:0] reg_mx, reg_my;

  // First-fit search; marks cells and returns the index, or -1
  function automatic int place_first_fit(int cols, int fx, int fy, logic [5:0] own);
    int rows, x, y;
    bit ok;
    rows = gtp_pkg::CELLS / cols;
    if (fx > cols) return -1;
    for (int i = 0; i < gtp_pkg::CELLS; i++) begin
      x = i % cols;
      y = i / cols;
      if (x + fx > cols || y + fy > rows) continue;
      ok = 1;
      for (int cx = x; cx < x + fx; cx++)
        for (int cy = y; cy < y + fy; cy++)
          if (map_copy[cy*cols+cx][6]) ok = 0;
      if (ok) begin
        for (int cx = x; cx < x + fx; cx++)
          for (int cy = y; cy < y + fy; cy++)
            map_copy[cy*cols+cx] = {1'b1, own};
        return i;
      end
    end
    return -1;
  endfunction

  function automatic tile_res_t predict_tile(logic [1:0] cmd, logic [63:0] d);
    tile_res_t r;
    longint w, h, clx, cly, cols, mx, my, lhs, bound, fx, fy, j;
    longint ow, oh, ox, oy, iw, ih, ix, iy, cell_idx;
    r = '0;
    w = longint'(d[17:6]); h = longint'(d[29:18]);
    clx = longint'(d[42:30]); cly = longint'(d[60:43]);
    cols = (reg_cols == 5'd0) ? 64'sd1 : longint'(reg_cols);
    mx = longint'(reg_mx); my = longint'(reg_my);
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (cmd == gtp_pkg::CMD_CLEAR) begin
      foreach (map_copy[k]) map_copy[k] = '0;
      r.status = gtp_pkg::ST_CLEARED;
    end else if (cmd == gtp_pkg::CMD_PLACE) begin
      lhs = 5 * (gtp_pkg::TILE_HEIGHT * w - gtp_pkg::TILE_WIDTH * h);
      bound = 2 * gtp_pkg::TILE_WIDTH * w;
      fx = 1; fy = 1;
      if (lhs > bound && cols > 1) fx = 2;
      else if (lhs < -bound) fy = 2;
      r.owner = d[5:0];
      j = longint'(place_first_fit(int'(cols), int'(fx), int'(fy), d[5:0]));
      if (j < 0) begin
        r.status = gtp_pkg::ST_NO_ROOM;
      end else begin
        ow = gtp_pkg::TILE_WIDTH * fx + mx * (fx - 1);
        oh = gtp_pkg::TILE_HEIGHT * fy + my * (fy - 1);
        ox = (j % cols) * (gtp_pkg::TILE_WIDTH + mx) + mx / 2;
        oy = (j / cols) * (gtp_pkg::TILE_HEIGHT + my) + my / 2;
        if (oh * w > h * ow) begin
          iw = ow; ih = ow * h / w; ix = ox; iy = oy + (oh - ih) / 2;
        end else begin
          iw = oh * w / h; ih = oh; ix = ox + (ow - iw) / 2; iy = oy;
        end
        r.status = gtp_pkg::ST_PLACED;
        r.ox = 18'(ox); r.oy = 18'(oy); r.ow = 10'(ow); r.oh = 10'(oh);
        r.ix = 18'(ix); r.iy = 18'(iy); r.iw = 10'(iw); r.ih = 10'(ih);
      end
    end else begin
      // truncate toward zero, as the divide of signed values does
      cell_idx = ((cly - my / 2) / (gtp_pkg::TILE_HEIGHT + my)) * cols
                 + (clx - mx / 2) / (gtp_pkg::TILE_WIDTH + mx);
      if (cell_idx >= 0 && cell_idx < gtp_pkg::CELLS && map_copy[cell_idx][6]) begin
        r.status = gtp_pkg::ST_HIT;
        r.owner = map_copy[cell_idx][5:0];
      end else begin
        r.status = gtp_pkg::ST_MISS;
      end
    end
    return r;
  endfunction

  // Track configuration and commands, compare results
  always @(posedge clk) begin
    tile_res_t got, want;
    if (!rst_n) begin
      foreach (map_copy[k]) map_copy[k] = '0;
      reg_cols = 5'd4; reg_mx = 8'd0; reg_my = 8'd10;
      fail_count <= 0;
      pending <= 0;
      expected_tiles.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtp_pkg::REG_COLUMNS:  reg_cols = cfg_data[4:0];
          gtp_pkg::REG_MARGIN_X: reg_mx = cfg_data;
          gtp_pkg::REG_MARGIN_Y: reg_my = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[5:0], out_tdata[23:6], out_tdata[41:24],
               out_tdata[51:42], out_tdata[61:52], out_tdata[79:62], out_tdata[97:80],
               out_tdata[107:98], out_tdata[117:108]};
        if (expected_tiles.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_tiles.pop_front();
          if (got.status !== want.status || got.owner !== want.owner ||
              got.ox !== want.ox || got.oy !== want.oy || got.ow !== want.ow ||
              got.oh !== want.oh || got.ix !== want.ix || got.iy !== want.iy ||
              got.iw !== want.iw || got.ih !== want.ih) begin
            $display({"%0t: mismatch st %0d/%0d own %0d/%0d outer %0d,%0d,%0d,%0d/",
                      "%0d,%0d,%0d,%0d inner %0d,%0d,%0d,%0d/%0d,%0d,%0d,%0d"},
                     $time, want.status, got.status, want.owner, got.owner,
                     want.ox, want.oy, want.ow, want.oh, got.ox, got.oy, got.ow, got.oh,
                     want.ix, want.iy, want.iw, want.ih, got.ix, got.iy, got.iw, got.ih);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready && in_tuser != gtp_pkg::CMD_UNUSED)
        expected_tiles.push_back(predict_tile(in_tuser, in_tdata));
      pending <= expected_tiles.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the grid tile placer
// Directed and random clear/place/lookup words over several grid settings,
// with random idling on both streams; a checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [63:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;
  logic         in_tready, out_tvalid, cfg_ready;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  int           fail_count, pending;
  bit           calm = 0;

  always #4 clk = ~clk;

  grid_tile_placer i_dut (.*);

  gtp_checker i_chk (.*);

  // Receiver: random stall bursts, none at the end
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  // Hold valid after the write; the caller drops it after the last one
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait for every result, then the longest command time
  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (320) @(posedge clk);
  endtask

  // Valid stays up after the accept; idling or drain drops it
  task automatic send_word(logic [1:0] cmd, logic [5:0] item, logic [11:0] w, logic [11:0] h,
                           logic [12:0] cx, logic [17:0] cy);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1; in_tuser <= cmd;
    in_tdata <= {3'b0, cy, cx, h, w, item};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_word();
    logic [11:0] w, h;
    int k;
    k = $urandom_range(0, 99);
    w = 12'($urandom); h = 12'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      w = 12'($urandom_range(1, 400)); h = 12'($urandom_range(1, 400));
    end
    if (k < 3)
      send_word(gtp_pkg::CMD_CLEAR, 6'($urandom), w, h, 13'($urandom), 18'($urandom));
    else if (k < 5)
      send_word(gtp_pkg::CMD_UNUSED, 6'($urandom), w, h, 13'($urandom), 18'($urandom));
    else if (k < 55)
      send_word(gtp_pkg::CMD_PLACE, 6'($urandom), w, h, 13'($urandom), 18'($urandom));
    else if (k < 85)
      send_word(gtp_pkg::CMD_LOOKUP, 6'd0, w, h, 13'($urandom_range(0, 1800)),
                18'($urandom_range(0, 12000)));
    else
      send_word(gtp_pkg::CMD_LOOKUP, 6'($urandom), w, h, 13'($urandom), 18'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: lookup and place commands, size extremes, zero sizes, unused code
    send_word(gtp_pkg::CMD_LOOKUP, 6'd0, 12'd1, 12'd1, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_PLACE, 6'd0, 12'd4095, 12'd1, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_PLACE, 6'd63, 12'd1, 12'd4095, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_PLACE, 6'd5, 12'd200, 12'd150, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_PLACE, 6'd6, 12'd0, 12'd0, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_PLACE, 6'd7, 12'd0, 12'd4095, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_UNUSED, 6'h3f, 12'hfff, 12'hfff, 13'h1fff, 18'h3ffff);
    send_word(gtp_pkg::CMD_LOOKUP, 6'd0, 12'd1, 12'd1, 13'd250, 18'd10);
    send_word(gtp_pkg::CMD_LOOKUP, 6'd0, 12'd1, 12'd1, 13'h1fff, 18'h3ffff);
    send_word(gtp_pkg::CMD_LOOKUP, 6'd0, 12'd1, 12'd1, 13'd900, 18'd5);
    drain();
    // Place a few tall tiles, then clear
    for (int i = 0; i < 6; i++)
      send_word(gtp_pkg::CMD_PLACE, 6'(i), 12'd1, 12'd4095, 13'd0, 18'd0);
    send_word(gtp_pkg::CMD_CLEAR, 6'd0, 12'd1, 12'd1, 13'd0, 18'd0);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(gtp_pkg::REG_COLUMNS, 8'd0);
                 write_reg(gtp_pkg::REG_MARGIN_X, 8'd255);
                 write_reg(gtp_pkg::REG_MARGIN_Y, 8'd0); end
        1: begin write_reg(gtp_pkg::REG_COLUMNS, 8'd1);
                 write_reg(gtp_pkg::REG_MARGIN_X, 8'd0);
                 write_reg(gtp_pkg::REG_MARGIN_Y, 8'd255); end
        2: begin write_reg(gtp_pkg::REG_COLUMNS, 8'd16);
                 write_reg(gtp_pkg::REG_MARGIN_X, 8'd1);
                 write_reg(gtp_pkg::REG_MARGIN_Y, 8'd1); end
        3: begin write_reg(gtp_pkg::REG_COLUMNS, 8'hff);
                 write_reg(gtp_pkg::REG_MARGIN_X, 8'd255);
                 write_reg(gtp_pkg::REG_MARGIN_Y, 8'd255); end
        default: begin write_reg(gtp_pkg::REG_COLUMNS, 8'($urandom));
                 write_reg(gtp_pkg::REG_MARGIN_X, 8'($urandom));
                 write_reg(gtp_pkg::REG_MARGIN_Y, 8'($urandom)); end
      endcase
      cfg_valid <= 0;
      if (ph == 7) calm = 1;
      for (int i = 0; i < 125; i++) random_word();
      drain();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
